// File: rtl/simt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package simt_pkg;
  localparam int unsigned WarpLanes   = 32;
  localparam int unsigned MemoryWords = 4096;
  localparam int unsigned LaneW  = $clog2(WarpLanes);
  localparam int unsigned RegAw  = LaneW + 5;
  localparam int unsigned MemAw  = $clog2(MemoryWords);
  localparam logic [31:0] InsnEbreak = 32'h0010_0073;
  localparam logic [31:0] InsnEcall  = 32'h0000_0073;
  localparam logic [11:0] CsrHart    = 12'hF14;
  localparam logic [15:0] StepLimitRst = 16'd1024;

  localparam logic [1:0] OpHostWr = 2'd0;
  localparam logic [1:0] OpHostRd = 2'd1;
  localparam logic [1:0] OpStart  = 2'd2;
  localparam logic [1:0] OpStep   = 2'd3;

  localparam logic [0:0] CfgStartAddr = 1'b0;
  localparam logic [0:0] CfgStepLimit = 1'b1;

  localparam logic [6:0] OpcLui = 7'h37, OpcAuipc = 7'h17, OpcJal = 7'h6F, OpcJalr = 7'h67;
  localparam logic [6:0] OpcBr = 7'h63, OpcLd = 7'h03, OpcSt = 7'h23, OpcImm = 7'h13;
  localparam logic [6:0] OpcReg = 7'h33, OpcSys = 7'h73;
  localparam logic [6:0] F7Alt = 7'h20;

  typedef struct packed {
    logic       stop;
    logic       halt;
  } stop_t;
endpackage
`default_nettype wire

// File: rtl/simt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module simt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/simt_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Combinational execute for one lane instruction.
module simt_alu import simt_pkg::*; (
  input  wire logic [31:0] inst_i,
  input  wire logic [31:0] pc_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] hart_i,
  output logic             wr_o,
  output logic [31:0]      val_o,
  output logic [31:0]      next_o,
  output logic             is_ld_o,
  output logic             is_st_o,
  output logic [31:0]      addr_o,
  output logic             brk_o,
  output logic             ecall_o
);
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [31:0] immi, imms, immb, immj, immu, sh_b, opb;
  logic [4:0] sh;
  logic slt, sltu;
  always_comb begin
    op = inst_i[6:0]; f3 = inst_i[14:12]; f7 = inst_i[31:25];
    immi = {{20{inst_i[31]}}, inst_i[31:20]};
    imms = {{20{inst_i[31]}}, inst_i[31:25], inst_i[11:7]};
    immb = {{19{inst_i[31]}}, inst_i[31], inst_i[7], inst_i[30:25], inst_i[11:8], 1'b0};
    immj = {{11{inst_i[31]}}, inst_i[31], inst_i[19:12], inst_i[20], inst_i[30:21], 1'b0};
    immu = {inst_i[31:12], 12'd0};
    opb = (op == OpcReg) ? b_i : immi;
    sh = opb[4:0];
    sh_b = 32'd0;
    slt = $signed(a_i) < $signed(opb);
    sltu = a_i < opb;
    wr_o = 1'b0; val_o = 32'd0; next_o = pc_i + 32'd4;
    is_ld_o = 1'b0; is_st_o = 1'b0; addr_o = a_i + immi;
    brk_o = 1'b0; ecall_o = 1'b0;
    case (op)
      OpcLui:   begin wr_o = 1'b1; val_o = immu; end
      OpcAuipc: begin wr_o = 1'b1; val_o = pc_i + immu; end
      OpcJal:   begin wr_o = 1'b1; val_o = pc_i + 32'd4; next_o = pc_i + immj; end
      OpcJalr:  begin wr_o = 1'b1; val_o = pc_i + 32'd4; next_o = (a_i + immi) & ~32'd1; end
      OpcBr: begin
        case (f3)
          3'd0: if (a_i == b_i) next_o = pc_i + immb;
          3'd1: if (a_i != b_i) next_o = pc_i + immb;
          3'd4: if ($signed(a_i) < $signed(b_i)) next_o = pc_i + immb;
          3'd5: if (!($signed(a_i) < $signed(b_i))) next_o = pc_i + immb;
          3'd6: if (a_i < b_i) next_o = pc_i + immb;
          3'd7: if (a_i >= b_i) next_o = pc_i + immb;
          default: ;
        endcase
      end
      OpcLd: is_ld_o = (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5});
      OpcSt: begin is_st_o = (f3 inside {3'd0, 3'd1, 3'd2}); addr_o = a_i + imms; end
      OpcImm, OpcReg: begin
        wr_o = 1'b1;
        case (f3)
          3'd0: begin
            if (op == OpcImm || f7 == 7'd0) val_o = a_i + opb;
            else if (f7 == F7Alt) val_o = a_i - opb;
            else wr_o = 1'b0;
          end
          3'd1: val_o = a_i << sh;
          3'd2: val_o = {31'd0, slt};
          3'd3: val_o = {31'd0, sltu};
          3'd4: val_o = a_i ^ opb;
          3'd5: begin
            if (f7 == 7'd0) val_o = a_i >> sh;
            else if (f7 == F7Alt) val_o = $unsigned($signed(a_i) >>> sh);
            else wr_o = 1'b0;
          end
          3'd6: val_o = a_i | opb;
          default: val_o = a_i & opb;
        endcase
        sh_b = val_o;
        val_o = sh_b;
      end
      OpcSys: begin
        if (inst_i == InsnEbreak) brk_o = 1'b1;
        else if (inst_i == InsnEcall) ecall_o = 1'b1;
        else if (f3 == 3'd1 || f3 == 3'd2) begin
          wr_o = 1'b1;
          val_o = (inst_i[31:20] == CsrHart) ? hart_i : 32'd0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/simt_rv32i_warp_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Payload
// s_axis   | in  | tdata: operation[1:0] word_address[13:2] write_word[45:14]
//          |     |        block_index[64:46] warp_index[72:65] thread_count[78:73]
// m_axis   | out | tdata: read_word[31:0] stopped[32] halted[33] timed_out[34]
// cfg      | in  | index 0 kernel_start_address, 1 step_limit
// Start: one register-file clearing sweep that also loads every lane pc with the start
// address. Step: inactive lanes are skipped; an active lane does pc read, fetch, two
// register reads, execute and retire, plus a second fetch when the fetch straddles two
// words; an in-memory load or store adds SMemRd, SMemW, SMemMod per byte and a second retire.
// Reset clears control and flags; lane pc and register memories are written by start.
// The output register holds a result until taken; no new request is taken meanwhile.
module simt_rv32i_warp_step import simt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // operation, word_address, write_word,
                                           // block_index, warp_index, thread_count
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // read_word, stopped, halted, timed_out
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam logic [4:0] SIdle = 5'd0, SHost = 5'd1, SHostW = 5'd2, SClr = 5'd3,
    SLane = 5'd4, SPcW = 5'd5, SRa = 5'd6, SRb = 5'd7, SFetch = 5'd8, SFetchW = 5'd9,
    SExec = 5'd10, SMemRd = 5'd11, SMemW = 5'd12, SMemMod = 5'd13, SRetire = 5'd14,
    SOut = 5'd15, SRaW = 5'd16, SFetch2 = 5'd17;

  logic [4:0] st_q;
  logic [31:0] start_q, active_q;
  logic [15:0] limit_q, steps_q;
  logic [18:0] blk_q; logic [7:0] wrp_q;
  stop_t flags_q;
  logic [RegAw-1:0] cnt_q;
  logic [LaneW-1:0] lane_q;
  logic [31:0] inst_q, pc_q, a_q, b_q, ld_q, rdw_q, addr_q, fw_q;
  logic [2:0] bcnt_q;
  logic [79:0] req_q;

  // memories
  logic rf_we; logic [RegAw-1:0] rf_wa, rf_ra; logic [31:0] rf_wd, rf_rd;
  logic pc_we; logic [LaneW-1:0] pc_wa, pc_ra; logic [31:0] pc_wd, pc_rd;
  logic mm_we; logic [MemAw-1:0] mm_wa, mm_ra; logic [31:0] mm_wd, mm_rd;
  simt_ram #(.Width(32), .Depth(WarpLanes*32)) u_rf (.clk_i, .we_i(rf_we), .waddr_i(rf_wa),
    .wdata_i(rf_wd), .raddr_i(rf_ra), .rdata_o(rf_rd));
  simt_ram #(.Width(32), .Depth(WarpLanes)) u_pc (.clk_i, .we_i(pc_we), .waddr_i(pc_wa),
    .wdata_i(pc_wd), .raddr_i(pc_ra), .rdata_o(pc_rd));
  simt_ram #(.Width(32), .Depth(MemoryWords)) u_mem (.clk_i, .we_i(mm_we), .waddr_i(mm_wa),
    .wdata_i(mm_wd), .raddr_i(mm_ra), .rdata_o(mm_rd));

  logic ex_wr, ex_ld, ex_st, ex_brk, ex_ecall;
  logic [31:0] ex_val, ex_next, ex_addr, hart;
  assign hart = {blk_q[18:0], 13'd0} | {19'd0, wrp_q, 5'd0} | {{(32-LaneW){1'b0}}, lane_q};
  simt_alu u_alu (.inst_i(inst_q), .pc_i(pc_q), .a_i(a_q), .b_i(b_q), .hart_i(hart),
    .wr_o(ex_wr), .val_o(ex_val), .next_o(ex_next), .is_ld_o(ex_ld), .is_st_o(ex_st),
    .addr_o(ex_addr), .brk_o(ex_brk), .ecall_o(ex_ecall));

  logic [1:0] r_op; logic [11:0] r_wa;
  assign r_op = req_q[1:0];
  assign r_wa = req_q[13:2];

  // access size and byte traffic
  logic [2:0] nbytes; logic [31:0] baddr; logic inside_ok;
  logic [32:0] aend;
  always_comb begin
    case (inst_q[13:12])
      2'd0: nbytes = 3'd1;
      2'd1: nbytes = 3'd2;
      default: nbytes = 3'd4;
    endcase
    aend = {1'b0, addr_q} + {30'd0, nbytes};
    inside_ok = aend <= 33'(MemoryWords * 4);
    baddr = addr_q + {29'd0, bcnt_q};
  end

  logic [7:0] mbyte, sbyte;
  assign mbyte = mm_rd[{baddr[1:0], 3'b000} +: 8];
  assign sbyte = b_q[{bcnt_q[1:0], 3'b000} +: 8];

  // misaligned fetch: two consecutive words, instruction picked from the pair
  logic [63:0] fpair;
  assign fpair = {mm_rd, fw_q};

  logic [31:0] ld_ext;
  always_comb begin
    case (inst_q[14:12])
      3'd0: ld_ext = {{24{ld_q[7]}}, ld_q[7:0]};
      3'd1: ld_ext = {{16{ld_q[15]}}, ld_q[15:0]};
      3'd4: ld_ext = {24'd0, ld_q[7:0]};
      3'd5: ld_ext = {16'd0, ld_q[15:0]};
      default: ld_ext = ld_q;
    endcase
  end

  logic timed; assign timed = steps_q >= limit_q;
  logic fetch_ok; assign fetch_ok = ({1'b0, pc_q} + 33'd4) <= 33'(MemoryWords * 4);

  // memory ports per state; SLane scans from lane_q inclusive, one inactive lane per cycle
  always_comb begin
    rf_we = 1'b0; rf_wa = cnt_q; rf_wd = 32'd0; rf_ra = {lane_q, inst_q[19:15]};
    pc_we = 1'b0; pc_wa = lane_q; pc_wd = ex_next; pc_ra = lane_q;
    mm_we = 1'b0; mm_wa = r_wa[MemAw-1:0]; mm_wd = req_q[45:14];
    mm_ra = r_wa[MemAw-1:0];
    case (st_q)
      SHost: mm_we = (r_op == OpHostWr) && ({20'd0, r_wa} < 32'(MemoryWords));
      SClr: begin
        rf_we = 1'b1; rf_wa = cnt_q;
        pc_we = 1'b1; pc_wa = cnt_q[RegAw-1 -: LaneW]; pc_wd = start_q;
      end
      SFetch: mm_ra = pc_q[MemAw+1:2];
      SFetchW: mm_ra = pc_q[MemAw+1:2] + MemAw'(1);
      SRa: rf_ra = {lane_q, inst_q[19:15]};
      SRaW: rf_ra = {lane_q, inst_q[24:20]};
      SMemRd: mm_ra = baddr[MemAw+1:2];
      SMemW: mm_ra = baddr[MemAw+1:2];
      SMemMod: begin
        mm_wa = baddr[MemAw+1:2];
        mm_wd = mm_rd;
        mm_wd[{baddr[1:0], 3'b000} +: 8] = sbyte;
        mm_we = ex_st;
      end
      SRetire: begin
        pc_we = 1'b1; pc_wd = ex_next;
        rf_wa = {lane_q, inst_q[11:7]};
        rf_wd = ex_ld ? ld_ext : ex_val;
        rf_we = (ex_wr || ex_ld) && (inst_q[11:7] != 5'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; start_q <= 32'd0; limit_q <= StepLimitRst; active_q <= 32'd0;
      steps_q <= 16'd0; blk_q <= 19'd0; wrp_q <= 8'd0; flags_q <= '0;
      cnt_q <= '0; lane_q <= '0; bcnt_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgStartAddr) start_q <= cfg_data_i;
        else limit_q <= cfg_data_i[15:0];
      end
      case (st_q)
        SIdle: if (s_axis_tvalid) begin
          req_q <= s_axis_tdata; rdw_q <= 32'd0;
          case (s_axis_tdata[1:0])
            OpStart: begin
              cnt_q <= '0; st_q <= SClr;
              blk_q <= s_axis_tdata[64:46]; wrp_q <= s_axis_tdata[72:65];
              steps_q <= 16'd0; flags_q <= '0;
              for (int i = 0; i < WarpLanes; i++)
                active_q[i] <= (s_axis_tdata[78:73] > 6'(i));
            end
            OpStep: begin
              lane_q <= '0;
              st_q <= (!flags_q.stop && !timed) ? SLane : SOut;
            end
            default: st_q <= SHost;
          endcase
        end
        SHostW: begin
          rdw_q <= ((r_op == OpHostRd) && ({20'd0, r_wa} < 32'(MemoryWords)))
                   ? mm_rd : 32'd0;
          st_q <= SOut;
        end
        SHost: st_q <= SHostW;
        SClr: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == RegAw'(WarpLanes*32-1)) st_q <= SOut;
        end
        SLane: begin
          if (active_q[lane_q]) st_q <= SPcW;
          else if (lane_q == LaneW'(WarpLanes-1)) begin
            steps_q <= steps_q + 16'd1; st_q <= SOut;
          end else lane_q <= lane_q + 1'b1;
        end
        SPcW: begin pc_q <= pc_rd; st_q <= SFetch; end
        SFetch: st_q <= SFetchW;
        SFetchW: begin
          if (pc_q[1:0] == 2'd0) begin
            inst_q <= fetch_ok ? mm_rd : 32'd0; st_q <= SRa;
          end else begin
            fw_q <= mm_rd; st_q <= SFetch2;
          end
        end
        SFetch2: begin
          inst_q <= fetch_ok ? fpair[{pc_q[1:0], 3'b000} +: 32] : 32'd0; st_q <= SRa;
        end
        SRa: st_q <= SRaW;
        SRaW: begin a_q <= (inst_q[19:15] == 5'd0) ? 32'd0 : rf_rd; st_q <= SRb; end
        SRb: begin
          b_q <= (inst_q[24:20] == 5'd0) ? 32'd0 : rf_rd; st_q <= SExec;
        end
        SExec: begin
          addr_q <= ex_addr; ld_q <= 32'd0; bcnt_q <= '0;
          if (ex_brk) begin flags_q.stop <= 1'b1; flags_q.halt <= 1'b1; end
          if (ex_ecall) flags_q.stop <= 1'b1;
          st_q <= SRetire;
        end
        SMemRd: st_q <= SMemW;
        SMemW: begin
          if (ex_ld) ld_q[{bcnt_q[1:0], 3'b000} +: 8] <= mbyte;
          st_q <= SMemMod;
        end
        SMemMod: begin
          bcnt_q <= bcnt_q + 3'd1;
          st_q <= ((bcnt_q + 3'd1) == nbytes) ? SRetire : SMemRd;
        end
        SRetire: begin
          if ((ex_ld || ex_st) && inside_ok && bcnt_q == 3'd0) st_q <= SMemRd;
          else if (lane_q == LaneW'(WarpLanes-1)) begin
            steps_q <= steps_q + 16'd1; st_q <= SOut;
          end else begin lane_q <= lane_q + 1'b1; st_q <= SLane; end
        end
        SOut: if (m_axis_tready) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end

  assign s_axis_tready = (st_q == SIdle);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = (st_q == SOut);
  assign m_axis_tdata = {5'd0, (!flags_q.stop && timed), flags_q.halt, flags_q.stop, rdw_q};
endmodule
`default_nettype wire

// File: rtl/simt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module simt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("overlap");
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[32]) else $error("halt w/o stop");
  a_to: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34] |-> !m_axis_tdata[32]) else $error("timeout");
endmodule
bind simt_rv32i_warp_step simt_checker u_chk (.*);
`default_nettype wire
